@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the route table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/dvrt_pkg.sv @@
// Types, codes and helpers shared by the route table modules.
package dvrt_pkg;

	localparam logic [1:0] REQ_LEARN  = 2'd0;
	localparam logic [1:0] REQ_TMO    = 2'd1;
	localparam logic [1:0] REQ_GC     = 2'd2;
	localparam logic [1:0] REQ_EXPORT = 2'd3;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_INSTALL  = 2'd1;
	localparam logic [1:0] KIND_WITHDRAW = 2'd2;
	localparam logic [1:0] KIND_EXPORT   = 2'd3;

	localparam logic [1:0] CFG_INFINITY = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_GC_HOLD  = 2'd2;

	localparam logic [7:0]  INFINITY_RST = 8'd16;
	localparam logic [30:0] TIMEOUT_RST  = 31'd180;
	localparam logic [30:0] GC_HOLD_RST  = 31'd120;

	localparam logic [15:0] FAMILY_IPV4 = 16'd2;
	localparam logic [5:0]  MAX_RESULTS = 6'd32;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 120;

	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [7:0]  metric;
		logic [31:0] gateway;
		logic [2:0]  iface;
		logic [31:0] stamp;
	} slot_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [2:0]  iface;
		logic [7:0]  metric;
	} result_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic probe;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic hold;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] len_to_mask(input logic [5:0] len);
		len_to_mask = ~(ALL_ONES >> len);
	endfunction

	function automatic result_t make_result(input logic [1:0] kind, input slot_word_t w,
			input logic [2:0] iface, input logic [7:0] metric);
		result_t r;
		r.kind    = kind;
		r.prefix  = w.prefix;
		r.len     = w.len;
		r.mask    = len_to_mask(w.len);
		r.gateway = w.gateway;
		r.iface   = iface;
		r.metric  = metric;
		make_result = r;
	endfunction

endpackage

@@ hw/rtl/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/dvrt_ctrl.sv @@
// Sequencer that walks the table once per request and closes the run.
`include "assert_macros.svh"
module dvrt_ctrl #(
	parameter int SLOTS = 32,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  dvrt_pkg::stat_t stat,
	output dvrt_pkg::cmd_t  cmd,
	output logic [AW-1:0]   rd_addr,
	output logic [AW-1:0]   ev_idx
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m1;

	assign s_tready = (state_q == ST_IDLE);
	assign cnt_m1   = cnt_q - CW'(1);
	assign rd_addr  = cnt_q[AW-1:0];
	assign ev_idx   = cnt_m1[AW-1:0];

	always_comb begin
		cmd.load  = s_tvalid && s_tready;
		cmd.probe = (state_q == ST_WALK) && (cnt_q != '0);
		cmd.rd_en = (state_q == ST_WALK) && !stat.hold && (cnt_q < CW'(SLOTS));
		cmd.fin   = (state_q == ST_FIN) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
					end
				end
				ST_WALK: begin
					if (!stat.hold) begin
						cnt_q <= cnt_q + CW'(1);
						if (cnt_q == CW'(SLOTS)) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (cmd.fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_load_starts_walk, clk, arst_n, cmd.load, state_q == ST_WALK && cnt_q == '0)
	`ASSERT_IMPLY(a_fin_needs_room, clk, arst_n, cmd.fin, stat.out_free)
	`ASSERT_IMPLY(a_no_read_past_end, clk, arst_n, cmd.rd_en, cnt_q < CW'(SLOTS))

endmodule

@@ hw/rtl/dvrt_datapath.sv @@
// Request decode, slot evaluation, table state and result registers.
`include "assert_macros.svh"
module dvrt_datapath #(
	parameter int SLOTS = 32,
	parameter int NUM_IFACES = 8,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_idx,
	input  logic [30:0]                          cfg_data,
	input  logic [dvrt_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [1:0]                           s_tuser,
	input  dvrt_pkg::cmd_t                       cmd,
	input  logic [AW-1:0]                        rd_addr,
	input  logic [AW-1:0]                        ev_idx,
	output dvrt_pkg::stat_t                      stat,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dvrt_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);

	localparam int WW = $bits(dvrt_pkg::slot_word_t);

	logic [7:0]  inf_q;
	logic [30:0] tmo_q;
	logic [30:0] gc_q;

	// Decoded request.
	logic [1:0]  typ_q;
	logic [31:0] now_q;
	logic [2:0]  ifc_q;
	logic        ok_q;
	logic        exp_ok_q;
	logic        unreach_q;
	logic [31:0] pfx_q;
	logic [5:0]  len_q;
	logic [7:0]  cand_q;
	logic [31:0] nh_q;

	logic [31:0] in_src, in_pfx, in_mask, in_nh, in_met, inv;
	logic [15:0] in_fam;
	logic [2:0]  in_ifc;
	logic [5:0]  in_len;
	logic [7:0]  met_c;
	logic [8:0]  met_p1;
	logic        ifc_ok;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] held_q;

	logic                 hit_found_q, free_found_q;
	logic [AW-1:0]        hit_idx_q, free_idx_q;
	dvrt_pkg::slot_word_t hit_w_q;
	logic [5:0]           n_q;

	dvrt_pkg::result_t pend_q, out_q, res, fin_res, inst_res, wd_res, empty_res;
	logic              pend_v_q, out_v_q, out_last_q;

	logic [WW-1:0]        rd_raw;
	dvrt_pkg::slot_word_t rd_w, tmo_w, new_w, wd_w, wr_w;
	logic                 we;
	logic [AW-1:0]        waddr;

	logic        v, h, room, tmo_hit, gc_hit, exp_hit, match, res_found, do_eval;
	logic [31:0] elapsed, limit;
	logic [7:0]  exp_met;
	logic        install, withdraw;
	logic [AW-1:0] inst_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= dvrt_pkg::INFINITY_RST;
			tmo_q <= dvrt_pkg::TIMEOUT_RST;
			gc_q  <= dvrt_pkg::GC_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dvrt_pkg::CFG_INFINITY: inf_q <= cfg_data[7:0];
				dvrt_pkg::CFG_TIMEOUT:  tmo_q <= cfg_data;
				dvrt_pkg::CFG_GC_HOLD:  gc_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		in_ifc  = s_tdata[34:32];
		in_src  = s_tdata[66:35];
		in_fam  = s_tdata[82:67];
		in_pfx  = s_tdata[114:83];
		in_mask = s_tdata[146:115];
		in_nh   = s_tdata[178:147];
		in_met  = s_tdata[210:179];
		inv     = ~in_mask;
		in_len  = 6'($countones(in_mask));
		ifc_ok  = (32'(in_ifc) < NUM_IFACES);
		met_c   = (in_met > {24'd0, inf_q}) ? inf_q : in_met[7:0];
		met_p1  = {1'b0, met_c} + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			typ_q    <= s_tuser;
			now_q    <= s_tdata[31:0];
			ifc_q    <= in_ifc;
			ok_q     <= (in_fam == dvrt_pkg::FAMILY_IPV4) && ifc_ok &&
				((inv & (inv + 32'd1)) == 32'd0);
			exp_ok_q <= ifc_ok;
			pfx_q    <= in_pfx & dvrt_pkg::len_to_mask(in_len);
			len_q    <= in_len;
			cand_q   <= (met_p1 > {1'b0, inf_q}) ? inf_q : met_p1[7:0];
			unreach_q <= (met_p1 > {1'b0, inf_q}) ? 1'b1 : (met_p1[7:0] == inf_q);
			nh_q     <= (in_nh == 32'd0) ? in_src : in_nh;
		end
	end

	dvrt_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_w),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	always_comb begin
		rd_w    = rd_raw;
		v       = valid_q[ev_idx];
		h       = held_q[ev_idx];
		elapsed = now_q - rd_w.stamp;
		limit   = {1'b0, tmo_q} + {1'b0, gc_q};
		room    = (n_q < dvrt_pkg::MAX_RESULTS);
		tmo_hit = (typ_q == dvrt_pkg::REQ_TMO) && v && !h &&
			(elapsed > {1'b0, tmo_q}) && room;
		gc_hit  = (typ_q == dvrt_pkg::REQ_GC) && v && h && (elapsed > limit);
		exp_hit = (typ_q == dvrt_pkg::REQ_EXPORT) && exp_ok_q && v &&
			(rd_w.iface != ifc_q) && room;
		match   = (typ_q == dvrt_pkg::REQ_LEARN) && v &&
			(rd_w.prefix == pfx_q) && (rd_w.len == len_q);
		res_found = tmo_hit || exp_hit;
		exp_met = (rd_w.metric > inf_q) ? inf_q : rd_w.metric;
		if (tmo_hit) begin
			res = dvrt_pkg::make_result(dvrt_pkg::KIND_WITHDRAW, rd_w, rd_w.iface, inf_q);
		end else begin
			res = dvrt_pkg::make_result(dvrt_pkg::KIND_EXPORT, rd_w, rd_w.iface, exp_met);
		end
		stat.out_free = !out_v_q || m_tready;
		stat.hold     = cmd.probe && res_found && pend_v_q && !stat.out_free;
		do_eval       = cmd.probe && !stat.hold;

		tmo_w        = rd_w;
		tmo_w.metric = inf_q;

		new_w.prefix  = pfx_q;
		new_w.len     = len_q;
		new_w.metric  = cand_q;
		new_w.gateway = nh_q;
		new_w.iface   = ifc_q;
		new_w.stamp   = now_q;

		wd_w        = hit_w_q;
		wd_w.metric = inf_q;
		wd_w.iface  = ifc_q;
		wd_w.stamp  = now_q;

		install  = (typ_q == dvrt_pkg::REQ_LEARN) && ok_q && !unreach_q &&
			(hit_found_q || free_found_q);
		withdraw = (typ_q == dvrt_pkg::REQ_LEARN) && ok_q && unreach_q && hit_found_q;
		inst_idx = hit_found_q ? hit_idx_q : free_idx_q;

		inst_res  = dvrt_pkg::make_result(dvrt_pkg::KIND_INSTALL, new_w, ifc_q, cand_q);
		wd_res    = dvrt_pkg::make_result(dvrt_pkg::KIND_WITHDRAW, wd_w, ifc_q, inf_q);
		empty_res = '0;
		if (typ_q == dvrt_pkg::REQ_LEARN) begin
			fin_res = install ? inst_res : (withdraw ? wd_res : empty_res);
		end else begin
			fin_res = pend_v_q ? pend_q : empty_res;
		end

		// Scan writes and the closing learn write never fall in the same cycle.
		we    = 1'b0;
		waddr = ev_idx;
		wr_w  = tmo_w;
		if (do_eval && tmo_hit) begin
			we = 1'b1;
		end else if (cmd.fin && (install || withdraw)) begin
			we    = 1'b1;
			waddr = install ? inst_idx : hit_idx_q;
			wr_w  = install ? new_w : wd_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			n_q          <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				n_q          <= '0;
			end
			if (do_eval) begin
				if (match && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if ((typ_q == dvrt_pkg::REQ_LEARN) && !v && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (gc_hit) begin
					valid_q[ev_idx] <= 1'b0;
				end
			end
			if (cmd.fin && install) begin
				valid_q[inst_idx] <= 1'b1;
			end
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (do_eval && res_found) begin
				n_q      <= n_q + 6'd1;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_eval) begin
			if (match && !hit_found_q) begin
				hit_idx_q <= ev_idx;
				hit_w_q   <= rd_w;
			end
			if ((typ_q == dvrt_pkg::REQ_LEARN) && !v && !free_found_q) begin
				free_idx_q <= ev_idx;
			end
			if (tmo_hit) begin
				held_q[ev_idx] <= 1'b1;
			end
		end
		if (cmd.fin && install) begin
			held_q[inst_idx] <= 1'b0;
		end
		if (cmd.fin && withdraw) begin
			held_q[hit_idx_q] <= 1'b1;
		end
		if (do_eval && res_found) begin
			pend_q <= res;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.fin) begin
			out_q      <= fin_res;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_q.metric, out_q.iface, out_q.gateway, out_q.mask,
		out_q.len, out_q.prefix};

	`ASSERT_NEXT(a_hold_keeps_pending, clk, arst_n, stat.hold, pend_v_q && $stable(n_q))
	`ASSERT_IMPLY(a_hold_only_when_full, clk, arst_n, stat.hold, out_v_q && pend_v_q)
	`ASSERT_IMPLY(a_count_capped, clk, arst_n, do_eval && res_found, n_q < dvrt_pkg::MAX_RESULTS)

endmodule

@@ hw/rtl/distance_vector_route_table.sv @@
// Top level of the distance-vector route table.
//
// Requests enter on the s_ channel (tuser = request type) and results leave on
// the m_ channel (tuser = result kind, tlast marks the final result of a run).
// Every request yields at least one result; a request with nothing to report
// yields a single kind-0 result with zero fields and tlast set.
// One request is worked at a time. After acceptance the sequencer walks every
// slot through the table RAM's registered read port, one slot per cycle unless
// the walk is paused, then closes the run. Learned entries commit to the table
// in the closing cycle. A result waits in a pending register and an output
// register; when both are full and the receiver stalls, the walk pauses on the
// current slot and resumes unchanged. Reset clears all slot valid bits at once
// and loads the register defaults; the table RAM needs no clearing pass.
// Configuration writes are taken on cfg_we at any edge.
module distance_vector_route_table #(
	parameter int TABLE_SLOTS = 32,
	parameter int NUM_IFACES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_idx,
	input  logic [30:0]                     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// now, iface, src_ip, family, route_prefix, route_mask, route_gateway, route_metric
	input  logic [dvrt_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// prefix, prefix length, mask, gateway, learned interface, metric
	output logic [dvrt_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	dvrt_pkg::cmd_t  cmd;
	dvrt_pkg::stat_t stat;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   ev_idx;

	dvrt_ctrl #(.SLOTS(TABLE_SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.ev_idx   (ev_idx)
	);

	dvrt_datapath #(.SLOTS(TABLE_SLOTS), .NUM_IFACES(NUM_IFACES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.ev_idx   (ev_idx),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the distance-vector route table.
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = 32;
	localparam int IFACES = 8;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]  req_type;
		logic [31:0] now;
		logic [2:0]  iface;
		logic [31:0] src_ip;
		logic [15:0] family;
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [31:0] metric;
	} route_req_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [2:0]  iface;
		logic [7:0]  metric;
		logic        last;
	} route_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [30:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [dvrt_pkg::IN_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [dvrt_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	distance_vector_route_table dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Predicted table contents and register settings.
	logic [7:0]  infinity;
	logic [30:0] timeout;
	logic [30:0] hold_time;
	logic        tbl_valid [SLOTS];
	logic [31:0] tbl_prefix [SLOTS];
	logic [5:0]  tbl_len [SLOTS];
	logic [7:0]  tbl_metric [SLOTS];
	logic [31:0] tbl_gateway [SLOTS];
	logic [2:0]  tbl_iface [SLOTS];
	logic [31:0] tbl_stamp [SLOTS];
	logic        tbl_held [SLOTS];

	route_req_t pending_reqs[$];
	route_res_t expected_routes[$];
	route_req_t in_flight;
	int errors = 0;
	bit calm = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic [31:0] clock_ticks = 32'd1000;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("testbench: errors");
		$finish;
	end

	function automatic logic [31:0] mask_of_len(input logic [5:0] len);
		if (len == 0)
			return 32'h0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic route_res_t slot_result(input logic [1:0] kind, input int i);
		route_res_t r;
		r.kind = kind;
		r.prefix = tbl_prefix[i];
		r.len = tbl_len[i];
		r.mask = mask_of_len(tbl_len[i]);
		r.gateway = tbl_gateway[i];
		r.iface = tbl_iface[i];
		r.metric = tbl_metric[i];
		r.last = 1'b0;
		return r;
	endfunction

	// Works out the results of one request and updates the predicted table.
	task automatic predict_routes(input route_req_t q);
		route_res_t runs[$];
		route_res_t r;
		logic [31:0] inv, pfx, nh, met, cand, limit;
		logic [5:0] len;
		int hit;
		hit = -1;
		limit = {1'b0, timeout} + {1'b0, hold_time};
		case (q.req_type)
			dvrt_pkg::REQ_LEARN: begin
				inv = ~q.mask;
				if (q.family == dvrt_pkg::FAMILY_IPV4 && q.iface < IFACES &&
						(inv & (inv + 32'd1)) == 32'd0) begin
					len = 6'($countones(q.mask));
					pfx = q.prefix & mask_of_len(len);
					met = (q.metric > infinity) ? {24'h0, infinity} : q.metric;
					cand = (met + 32'd1 > infinity) ? {24'h0, infinity} : met + 32'd1;
					nh = (q.gateway == 0) ? q.src_ip : q.gateway;
					for (int i = 0; i < SLOTS && hit < 0; i++)
						if (tbl_valid[i] && tbl_prefix[i] == pfx && tbl_len[i] == len)
							hit = i;
					if (cand == {24'h0, infinity}) begin
						if (hit >= 0) begin
							tbl_held[hit] = 1;
							tbl_stamp[hit] = q.now;
							tbl_iface[hit] = q.iface;
							tbl_metric[hit] = infinity;
							runs.push_back(slot_result(dvrt_pkg::KIND_WITHDRAW, hit));
						end
					end else begin
						for (int i = 0; i < SLOTS && hit < 0; i++)
							if (!tbl_valid[i])
								hit = i;
						if (hit >= 0) begin
							tbl_valid[hit] = 1;
							tbl_prefix[hit] = pfx;
							tbl_len[hit] = len;
							tbl_metric[hit] = cand[7:0];
							tbl_gateway[hit] = nh;
							tbl_iface[hit] = q.iface;
							tbl_stamp[hit] = q.now;
							tbl_held[hit] = 0;
							runs.push_back(slot_result(dvrt_pkg::KIND_INSTALL, hit));
						end
					end
				end
			end
			dvrt_pkg::REQ_TMO: begin
				for (int i = 0; i < SLOTS && runs.size() < dvrt_pkg::MAX_RESULTS; i++)
					if (tbl_valid[i] && !tbl_held[i] &&
							(q.now - tbl_stamp[i]) > {1'b0, timeout}) begin
						tbl_metric[i] = infinity;
						tbl_held[i] = 1;
						runs.push_back(slot_result(dvrt_pkg::KIND_WITHDRAW, i));
					end
			end
			dvrt_pkg::REQ_GC: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && tbl_held[i] && (q.now - tbl_stamp[i]) > limit)
						tbl_valid[i] = 0;
			end
			default: begin
				for (int i = 0; i < SLOTS && runs.size() < dvrt_pkg::MAX_RESULTS; i++)
					if (tbl_valid[i] && tbl_iface[i] != q.iface) begin
						r = slot_result(dvrt_pkg::KIND_EXPORT, i);
						if (r.metric > infinity)
							r.metric = infinity;
						runs.push_back(r);
					end
			end
		endcase
		if (runs.size() == 0) begin
			r = '{default: '0};
			r.kind = dvrt_pkg::KIND_NONE;
			runs.push_back(r);
		end
		runs[runs.size() - 1].last = 1'b1;
		foreach (runs[k])
			expected_routes.push_back(runs[k]);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_routes(in_flight);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					in_flight = pending_reqs.pop_front();
					s_tuser <= in_flight.req_type;
					s_tdata <= {5'b0, in_flight.metric, in_flight.gateway, in_flight.mask,
						in_flight.prefix, in_flight.family, in_flight.src_ip, in_flight.iface,
						in_flight.now};
					s_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 16);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result monitor and stall generator.
	always @(posedge clk) begin
		route_res_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.prefix = m_tdata[31:0];
				got.len = m_tdata[37:32];
				got.mask = m_tdata[69:38];
				got.gateway = m_tdata[101:70];
				got.iface = m_tdata[104:102];
				got.metric = m_tdata[112:105];
				got.last = m_tlast;
				if (expected_routes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
					errors++;
				end else begin
					want = expected_routes.pop_front();
					compare_field("kind", 32'(want.kind), 32'(got.kind));
					compare_field("prefix", want.prefix, got.prefix);
					compare_field("length", 32'(want.len), 32'(got.len));
					compare_field("mask", want.mask, got.mask);
					compare_field("gateway", want.gateway, got.gateway);
					compare_field("iface", 32'(want.iface), 32'(got.iface));
					compare_field("metric", 32'(want.metric), 32'(got.metric));
					compare_field("last", 32'(want.last), 32'(got.last));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					recv_gap = $urandom_range(1, 16);
			end
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || s_tvalid || expected_routes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			dvrt_pkg::CFG_INFINITY: infinity = value[7:0];
			dvrt_pkg::CFG_TIMEOUT: timeout = value;
			default: hold_time = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic route_req_t scan_req(input logic [1:0] kind, input logic [31:0] at,
			input logic [2:0] ifc);
		route_req_t q;
		q = '{default: '0};
		q.req_type = kind;
		q.now = at;
		q.iface = ifc;
		q.src_ip = $urandom;
		q.family = 16'($urandom);
		q.prefix = $urandom;
		q.mask = $urandom;
		q.gateway = $urandom;
		q.metric = $urandom;
		return q;
	endfunction

	function automatic route_req_t entry_req(input logic [31:0] at, input logic [2:0] ifc,
			input logic [31:0] pfx, input logic [5:0] len, input logic [31:0] nh,
			input logic [31:0] met);
		route_req_t q;
		q = scan_req(dvrt_pkg::REQ_LEARN, at, ifc);
		q.family = dvrt_pkg::FAMILY_IPV4;
		q.prefix = pfx;
		q.mask = mask_of_len(len);
		q.gateway = nh;
		q.metric = met;
		return q;
	endfunction

	// Well-formed entry whose prefix starts with one of 40 top bytes, so matches and a full table both occur.
	function automatic route_req_t pool_entry();
		int p;
		logic [31:0] met;
		p = $urandom_range(0, 39);
		case ($urandom_range(0, 9))
			0: met = $urandom;
			1, 2: met = {24'h0, infinity};
			default: met = $urandom_range(0, 20);
		endcase
		return entry_req(clock_ticks, 3'($urandom), {p[7:0], 24'($urandom)}, 6'(8 + p % 9),
			($urandom_range(0, 3) == 0) ? 32'h0 : $urandom, met);
	endfunction

	task automatic random_phase(input int count);
		route_req_t q;
		for (int n = 0; n < count; n++) begin
			clock_ticks += $urandom_range(0, 60);
			case ($urandom_range(0, 19))
				0, 1: q = scan_req(dvrt_pkg::REQ_TMO, clock_ticks, 3'($urandom));
				2: q = scan_req(dvrt_pkg::REQ_GC, clock_ticks, 3'($urandom));
				3, 4: q = scan_req(dvrt_pkg::REQ_EXPORT, clock_ticks, 3'($urandom));
				5: begin
					q = scan_req(dvrt_pkg::REQ_LEARN, clock_ticks, 3'($urandom));
					if ($urandom_range(0, 1) == 0)
						q.family = dvrt_pkg::FAMILY_IPV4;
				end
				6: q = entry_req($urandom, 3'($urandom), $urandom, 6'($urandom_range(0, 32)),
					$urandom, $urandom_range(0, 255));
				default: q = pool_entry();
			endcase
			pending_reqs.push_back(q);
		end
	endtask

	initial begin
		route_req_t q;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = dvrt_pkg::CFG_INFINITY;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = dvrt_pkg::REQ_LEARN;
		m_tready = 1'b0;
		infinity = dvrt_pkg::INFINITY_RST;
		timeout = dvrt_pkg::TIMEOUT_RST;
		hold_time = dvrt_pkg::GC_HOLD_RST;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: installs, updates, withdraws, drops and every scan kind.
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_EXPORT, 32'h0, 3'd0));
		pending_reqs.push_back(entry_req(32'd10, 3'd1, 32'hC0A8_01FF, 6'd24, 32'h0A00_0001, 32'd1));
		pending_reqs.push_back(entry_req(32'd11, 3'd7, 32'hFFFF_FFFF, 6'd32, 32'h0, 32'd0));
		pending_reqs.push_back(entry_req(32'd12, 3'd2, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 32'd3));
		q = entry_req(32'd13, 3'd1, 32'h0A00_0000, 6'd8, 32'h1, 32'd2);
		q.family = 16'hFFFF;
		pending_reqs.push_back(q);
		q.family = dvrt_pkg::FAMILY_IPV4;
		q.mask = 32'hFF00_FF00;
		pending_reqs.push_back(q);
		pending_reqs.push_back(entry_req(32'd14, 3'd3, 32'h0B00_0000, 6'd8, 32'h2, 32'hFFFF_FFFF));
		pending_reqs.push_back(entry_req(32'd15, 3'd4, 32'hC0A8_0100, 6'd24, 32'h0A00_0009, 32'd15));
		pending_reqs.push_back(entry_req(32'd16, 3'd5, 32'hC0A8_0100, 6'd24, 32'h0A00_0009, 32'd7));
		pending_reqs.push_back(entry_req(32'd17, 3'd6, 32'hC0A8_0100, 6'd24, 32'h0, 32'd16));
		pending_reqs.push_back(entry_req(32'd18, 3'd0, 32'hC0A8_0100, 6'd24, 32'h0, 32'd99));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_EXPORT, 32'd20, 3'd7));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_EXPORT, 32'd20, 3'd0));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_TMO, 32'd190, 3'd0));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_TMO, 32'd1000, 3'd0));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_GC, 32'd300, 3'd0));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_GC, 32'hFFFF_0000, 3'd0));
		pending_reqs.push_back(scan_req(dvrt_pkg::REQ_EXPORT, 32'hFFFF_FFFF, 3'd2));
		wait_idle();

		// Extremes of the registers.
		write_reg(dvrt_pkg::CFG_INFINITY, 31'd255);
		write_reg(dvrt_pkg::CFG_TIMEOUT, 31'd1);
		write_reg(dvrt_pkg::CFG_GC_HOLD, 31'd1);
		random_phase(20);
		wait_idle();
		write_reg(dvrt_pkg::CFG_INFINITY, 31'd1);
		random_phase(8);
		wait_idle();
		write_reg(dvrt_pkg::CFG_INFINITY, 31'd0);
		random_phase(6);
		wait_idle();
		write_reg(dvrt_pkg::CFG_INFINITY, 31'd16);
		write_reg(dvrt_pkg::CFG_TIMEOUT, 31'h7FFF_FFFF);
		write_reg(dvrt_pkg::CFG_GC_HOLD, 31'h7FFF_FFFF);
		random_phase(15);
		wait_idle();
		write_reg(dvrt_pkg::CFG_TIMEOUT, 31'd180);
		write_reg(dvrt_pkg::CFG_GC_HOLD, 31'd120);
		random_phase(20);
		wait_idle();
		calm = 1;
		random_phase(15);
		wait_idle();

		if (errors == 0 && expected_routes.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_ram.sv
hw/rtl/dvrt_ctrl.sv
hw/rtl/dvrt_datapath.sv
hw/rtl/distance_vector_route_table.sv
tb/sv/testbench.sv
